// ===== rtl/ptwt_pkg.sv =====
package ptwt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int ADDR_W  = 16;
  localparam int SEQ_W   = 16;
  localparam int STAMP_W = 32;

  // opcodes
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_PING = 2'd1;
  localparam logic [1:0] OP_PONG = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_TX_PING  = 3'd0;
  localparam logic [2:0] KIND_TX_PONG  = 3'd1;
  localparam logic [2:0] KIND_ANSWERED = 3'd2;
  localparam logic [2:0] KIND_EXPIRED  = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_PEER = 2'd1;
  localparam logic [1:0] ERR_NO_SEQ  = 2'd2;
  localparam logic [1:0] ERR_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [ADDR_W-1:0]  peer_address;
    logic [ADDR_W-1:0]  local_address;
    logic [SEQ_W-1:0]   seq_in;
    logic [STAMP_W-1:0] stamp_in;
    logic [STAMP_W-1:0] expiry_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         result_kind;
    logic [ADDR_W-1:0]  to_address;
    logic [ADDR_W-1:0]  from_address;
    logic [SEQ_W-1:0]   seq_out;
    logic [STAMP_W-1:0] stamp_out;
    logic [STAMP_W-1:0] round_trip_ms;
    logic [1:0]         error_code;
    logic               last_result;
  } out_item_t;

  // one pending ping in the table
  typedef struct packed {
    logic [ADDR_W-1:0]  peer;
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] sent;
    logic [STAMP_W-1:0] limit;
  } entry_t;

endpackage

// ===== rtl/ptwt_in_if.sv =====
interface ptwt_in_if;
  import ptwt_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ptwt_out_if.sv =====
interface ptwt_out_if;
  import ptwt_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ptwt_table.sv =====
module ptwt_table (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ptwt_pkg::IDX_W-1:0] waddr,
  input  ptwt_pkg::entry_t      wdata,
  input  logic                  re,
  input  logic [ptwt_pkg::IDX_W-1:0] raddr,
  output ptwt_pkg::entry_t      rdata
);
  import ptwt_pkg::*;

  entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ping_tracker_with_timeouts_unit.sv =====
// Ping tracker with round-trip timing and timeouts.
// in_ch carries one event per transaction: send ping, received ping,
// received pong or a one millisecond tick. out_ch carries the results;
// last_result marks the final result of each event; a tick that expires
// no entry gives no result. cfg_we/cfg_wdata write own_address, the source
// used when a send gives source zero. A received ping skips the table walk:
// the finish state loads its result into the output register and returns
// to idle in the same cycle. Send, pong and tick events walk the pending
// table one entry per cycle, unless a blocked receiver stalls the walk,
// through a single compare and subtract unit fed from the table memory's
// registered read port; the finish state then gives the final result. A
// new event is taken only once the unit is back in idle; in_ch.ready is
// high only between events.
// Results go through a one-deep output register: an event is taken while
// the previous final result still waits, and a blocked receiver freezes
// the table walk in place without losing any result.
// Reset clears the clock, sequence counter, all pending valid bits and
// own_address; the table memory itself needs no clearing.
module ping_tracker_with_timeouts_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ptwt_pkg::ADDR_W-1:0]  cfg_wdata,
  ptwt_in_if.sink                      in_ch,
  ptwt_out_if.source                   out_ch
);
  import ptwt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  logic [ADDR_W-1:0]  own_address;
  logic [STAMP_W-1:0] clock_ms;
  logic [SEQ_W-1:0]   next_sequence;
  logic [TABLE_DEPTH-1:0] pend_valid;

  // current event
  logic [1:0]         cur_op;
  logic [ADDR_W-1:0]  cur_peer;
  logic [ADDR_W-1:0]  cur_src;
  logic [SEQ_W-1:0]   cur_seq;
  logic [STAMP_W-1:0] cur_stamp;
  logic [STAMP_W-1:0] cur_limit;

  // table walk
  logic [IDX_W-1:0]   rd_idx;
  logic               issue_done;
  logic               ev_valid;
  logic [IDX_W-1:0]   ev_idx;
  entry_t             rd_entry;

  // walk findings
  logic               found;
  logic [IDX_W-1:0]   slot;
  logic               free_found;
  logic [IDX_W-1:0]   free_slot;
  logic               peer_seen;
  logic [STAMP_W-1:0] rtt;
  logic               held_valid;
  out_item_t          held;
  logic [CNT_W-1:0]   exp_count;

  // output register
  logic               out_valid;
  out_item_t          out_data;

  logic               in_fire;
  logic               out_free;
  logic [STAMP_W-1:0] age;
  logic               ent_valid;
  logic               peer_hit;
  logic               send_hit;
  logic               expired;
  out_item_t          exp_res;
  logic               scan_push;
  logic               advance;
  logic               scan_eval;
  logic               rd_en;
  out_item_t          fin_res;
  logic               fin_need;
  logic               fin_go;
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_waddr;
  entry_t             tbl_wdata;

  assign in_ch.ready  = (state == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // shared age unit and per-entry compares
  assign age       = clock_ms - rd_entry.sent;
  assign ent_valid = pend_valid[ev_idx];
  assign peer_hit  = ent_valid && (rd_entry.peer == cur_peer);
  assign send_hit  = peer_hit && (rd_entry.seq == cur_seq);
  assign expired   = ent_valid && (age > rd_entry.limit) &&
                     (exp_count < CNT_W'(MAX_RESULTS));

  always_comb begin
    exp_res              = '0;
    exp_res.result_kind  = KIND_EXPIRED;
    exp_res.to_address   = rd_entry.peer;
    exp_res.seq_out      = rd_entry.seq;
    exp_res.error_code   = ERR_NONE;
  end

  // a second expiry pushes the held one; stall if the receiver is blocked
  assign scan_push = (state == S_SCAN) && ev_valid && (cur_op == OP_TICK) &&
                     expired && held_valid;
  assign advance   = !(scan_push && !out_free);
  assign scan_eval = (state == S_SCAN) && ev_valid && advance;
  assign rd_en     = (state == S_SCAN) && advance && !issue_done;

  // final result of the event
  always_comb begin
    fin_res   = '0;
    fin_need  = 1'b1;
    tbl_we    = 1'b0;
    tbl_waddr = found ? slot : free_slot;
    tbl_wdata = '{peer: cur_peer, seq: cur_seq, sent: clock_ms, limit: cur_limit};
    case (cur_op)
      OP_SEND: begin
        fin_res.to_address = cur_peer;
        fin_res.seq_out    = cur_seq;
        if (found || free_found) begin
          fin_res.result_kind  = KIND_TX_PING;
          fin_res.from_address = cur_src;
          fin_res.stamp_out    = clock_ms;
          fin_res.error_code   = ERR_NONE;
          tbl_we               = (state == S_FINISH) && out_free;
        end else begin
          fin_res.result_kind = KIND_ERROR;
          fin_res.error_code  = ERR_FULL;
        end
      end
      OP_PING: begin
        fin_res.result_kind  = KIND_TX_PONG;
        fin_res.to_address   = cur_peer;
        fin_res.from_address = cur_src;
        fin_res.seq_out      = cur_seq;
        fin_res.stamp_out    = cur_stamp;
        fin_res.error_code   = ERR_NONE;
      end
      OP_PONG: begin
        fin_res.to_address = cur_peer;
        fin_res.seq_out    = cur_seq;
        if (found) begin
          fin_res.result_kind   = KIND_ANSWERED;
          fin_res.round_trip_ms = rtt;
          fin_res.error_code    = ERR_NONE;
        end else begin
          fin_res.result_kind = KIND_ERROR;
          fin_res.error_code  = peer_seen ? ERR_NO_SEQ : ERR_NO_PEER;
        end
      end
      default: begin
        fin_res  = held;
        fin_need = held_valid;
      end
    endcase
    fin_res.last_result = 1'b1;
  end

  assign fin_go = !fin_need || out_free;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (in_ch.data.opcode == OP_PING) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_done && !ev_valid) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_we) begin
      own_address <= cfg_wdata;
    end
  end

  // clock and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms      <= '0;
      next_sequence <= '0;
    end else if (in_fire) begin
      if (in_ch.data.opcode == OP_TICK) begin
        clock_ms <= clock_ms + STAMP_W'(1);
      end
      if (in_ch.data.opcode == OP_SEND) begin
        next_sequence <= next_sequence + SEQ_W'(1);
      end
    end
  end

  // latch the event
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_op    <= in_ch.data.opcode;
      cur_peer  <= in_ch.data.peer_address;
      cur_stamp <= in_ch.data.stamp_in;
      cur_limit <= in_ch.data.expiry_limit;
      if (in_ch.data.opcode == OP_SEND) begin
        cur_src <= (in_ch.data.local_address != '0) ? in_ch.data.local_address
                                                    : own_address;
        cur_seq <= next_sequence;
      end else begin
        cur_src <= in_ch.data.local_address;
        cur_seq <= in_ch.data.seq_in;
      end
    end
  end

  // table walk: address issue and evaluate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      issue_done <= 1'b0;
      ev_valid   <= 1'b0;
    end else if (in_fire) begin
      rd_idx     <= '0;
      issue_done <= 1'b0;
      ev_valid   <= 1'b0;
    end else if ((state == S_SCAN) && advance) begin
      ev_valid <= !issue_done;
      if (!issue_done) begin
        ev_idx <= rd_idx;
        if (rd_idx == IDX_W'(TABLE_DEPTH - 1)) begin
          issue_done <= 1'b1;
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
    end
  end

  // walk findings
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      peer_seen  <= 1'b0;
      held_valid <= 1'b0;
      exp_count  <= '0;
    end else if (in_fire) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      peer_seen  <= 1'b0;
      held_valid <= 1'b0;
      exp_count  <= '0;
    end else if (scan_eval) begin
      if (!ent_valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= ev_idx;
      end
      if (peer_hit) begin
        peer_seen <= 1'b1;
      end
      if (send_hit && !found) begin
        found <= 1'b1;
        slot  <= ev_idx;
        rtt   <= age;
      end
      if ((cur_op == OP_TICK) && expired) begin
        held_valid <= 1'b1;
        held       <= exp_res;
        exp_count  <= exp_count + CNT_W'(1);
      end
    end else if ((state == S_FINISH) && fin_go) begin
      held_valid <= 1'b0;
    end
  end

  // pending valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= '0;
    end else if (scan_eval && (cur_op == OP_TICK) && expired) begin
      pend_valid[ev_idx] <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      if (tbl_we) begin
        pend_valid[tbl_waddr] <= 1'b1;
      end else if ((cur_op == OP_PONG) && found) begin
        pend_valid[slot] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_push && out_free) begin
      out_valid <= 1'b1;
    end else if ((state == S_FINISH) && fin_need && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_push && out_free) begin
      out_data <= held;
    end else if ((state == S_FINISH) && fin_need && out_free) begin
      out_data <= fin_res;
    end
  end

  ptwt_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

`ifndef SYNTHESIS
  a_tick_advances_clock: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_ch.data.opcode == OP_TICK) |=>
      clock_ms == $past(clock_ms) + STAMP_W'(1))
    else $error("clock did not advance on tick");

  a_send_takes_sequence: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_ch.data.opcode == OP_SEND) |=>
      (next_sequence == $past(next_sequence) + SEQ_W'(1)) &&
      (cur_seq == $past(next_sequence)))
    else $error("send did not take the next sequence number");

  a_no_held_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !held_valid && !ev_valid)
    else $error("walk state left over in idle");

  a_last_ends_event: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && fin_need && out_free |=>
      out_valid && out_data.last_result && (state == S_IDLE))
    else $error("final result not followed by idle");

  a_mid_results_not_last: assert property (@(posedge clk) disable iff (rst)
    scan_push && out_free |=> out_valid && !out_data.last_result)
    else $error("intermediate expiry marked last");
`endif

endmodule
